>>> sv/ahfr_pkg.sv
// shared types, constants and functions for the ascii hex frame receiver
// no dependencies; imported by every module of the block

package ahfr_pkg;

	localparam int TAIL_BYTES     = 10;
	localparam int POSITION_BITS  = 17;
	localparam int PAYLOAD_OFFSET = 13;
	localparam int MIN_FRAME      = 23;
	localparam int ADDR_FIRST     = 1;
	localparam int ADDR_LAST      = 8;
	localparam int LEN_FIRST      = 9;
	localparam int LEN_LAST       = 12;
	localparam int CRC_DIGITS     = 8;
	localparam int OUT_DATA_BITS  = 96;

	localparam logic [7:0]  CHAR_COLON = 8'h3a;
	localparam logic [7:0]  CHAR_CR    = 8'h0d;
	localparam logic [7:0]  CHAR_LF    = 8'h0a;
	localparam logic [31:0] CRC_POLY   = 32'hedb88320;
	localparam logic [31:0] CRC_INIT   = 32'hffffffff;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_START = 3'd1,
		ST_BAD_END   = 3'd2,
		ST_CRC_ERR   = 3'd3,
		ST_SHORT     = 3'd4
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		logic        ok;
		logic [3:0]  val;
	} hex_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [31:0] address;
		logic [15:0] payload_length;
		logic [31:0] received_crc;
	} result_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

>>> sv/ahfr_tail_check.sv
// end-of-frame checks: crc fold, tail crc digit parse and status priority
// depends on ahfr_pkg

module ahfr_tail_check
	import ahfr_pkg::*;
(
	input  logic [7:0]  tail [TAIL_BYTES],
	input  logic [31:0] crc_reg,
	input  logic        fold_oldest,
	input  logic        start_ok,
	input  logic        too_short,
	input  logic [7:0]  last_byte,
	output status_t     status,
	output logic [31:0] received_crc
);

	logic [31:0] crc_final;
	logic [31:0] rx;
	logic        frz;
	hex_t        d;

	always_comb begin
		crc_final = fold_oldest ? crc_byte(crc_reg, tail[0]) : crc_reg;
		crc_final = ~crc_final;
	end

	// digits until the first non-hex character, then frozen
	always_comb begin
		rx  = 32'd0;
		frz = 1'b0;
		d   = '0;
		for (int i = 1; i <= CRC_DIGITS; i++) begin
			d = hex_value(tail[i]);
			if (!frz) begin
				if (!d.ok) begin
					frz = 1'b1;
				end else begin
					rx = {rx[27:0], d.val};
				end
			end
		end
	end

	always_comb begin
		priority if (!start_ok) begin
			status = ST_BAD_START;
		end else if (too_short) begin
			status = ST_SHORT;
		end else if (tail[TAIL_BYTES-1] != CHAR_CR || last_byte != CHAR_LF) begin
			status = ST_BAD_END;
		end else if (rx != crc_final) begin
			status = ST_CRC_ERR;
		end else begin
			status = ST_OK;
		end
	end

	assign received_crc = rx;

endmodule

>>> sv/ahfr_frame.sv
// frame state: position, header parse, tail window and running crc
// depends on ahfr_pkg and ahfr_tail_check

module ahfr_frame
	import ahfr_pkg::*;
#(
	parameter int POS_BITS = POSITION_BITS
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic [7:0] rx_byte,
	input  logic    frame_end,
	output logic    res_valid,
	output result_t res
);

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	logic [POS_BITS-1:0] pos_q;
	logic                start_ok_q;
	logic [31:0]         addr_q;
	logic                addr_frz_q;
	logic [15:0]         len_q;
	logic                len_frz_q;
	logic [7:0]          tail_q [TAIL_BYTES];
	logic [31:0]         crc_q;

	logic                pos_zero;
	logic                in_addr;
	logic                in_len;
	logic                fold;
	logic                start_ok_now;
	logic                too_short;
	logic                is_payload;
	logic [POS_BITS-1:0] pay_off;
	hex_t                hv;
	status_t             status;
	logic [31:0]         rx_crc;

	assign pos_zero = (pos_q == '0);
	assign in_addr  = (pos_q >= POS_BITS'(ADDR_FIRST)) && (pos_q <= POS_BITS'(ADDR_LAST));
	assign in_len   = (pos_q >= POS_BITS'(LEN_FIRST)) && (pos_q <= POS_BITS'(LEN_LAST));
	assign fold     = (pos_q >= POS_BITS'(TAIL_BYTES));
	assign pay_off  = pos_q - POS_BITS'(PAYLOAD_OFFSET);
	assign is_payload = (pos_q >= POS_BITS'(PAYLOAD_OFFSET))
		&& (pay_off < POS_BITS'(len_q));
	assign start_ok_now = pos_zero ? (rx_byte == CHAR_COLON) : start_ok_q;
	assign too_short    = (pos_q < POS_BITS'(MIN_FRAME - 1));
	assign hv           = hex_value(rx_byte);

	ahfr_tail_check u_tail (
		.tail         (tail_q),
		.crc_reg      (crc_q),
		.fold_oldest  (fold),
		.start_ok     (start_ok_now),
		.too_short    (too_short),
		.last_byte    (rx_byte),
		.status       (status),
		.received_crc (rx_crc)
	);

	always_comb begin
		res = '0;
		res_valid = 1'b0;
		if (frame_end) begin
			res_valid          = 1'b1;
			res.kind           = KIND_STATUS;
			res.status         = status;
			res.address        = addr_q;
			res.payload_length = len_q;
			res.received_crc   = rx_crc;
		end else if (is_payload) begin
			res_valid        = 1'b1;
			res.kind         = KIND_PAYLOAD;
			res.payload_byte = rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			start_ok_q <= 1'b0;
			addr_q     <= '0;
			addr_frz_q <= 1'b0;
			len_q      <= '0;
			len_frz_q  <= 1'b0;
			crc_q      <= CRC_INIT;
			for (int i = 0; i < TAIL_BYTES; i++) begin
				tail_q[i] <= '0;
			end
		end else if (step) begin
			if (frame_end) begin
				// final byte: back to the idle frame state
				pos_q      <= '0;
				start_ok_q <= 1'b0;
				addr_q     <= '0;
				addr_frz_q <= 1'b0;
				len_q      <= '0;
				len_frz_q  <= 1'b0;
				crc_q      <= CRC_INIT;
				for (int i = 0; i < TAIL_BYTES; i++) begin
					tail_q[i] <= '0;
				end
			end else begin
				if (pos_zero) begin
					start_ok_q <= (rx_byte == CHAR_COLON);
				end
				if (in_addr && !addr_frz_q) begin
					if (!hv.ok) begin
						addr_frz_q <= 1'b1;
					end else begin
						addr_q <= {addr_q[27:0], hv.val};
					end
				end
				if (in_len && !len_frz_q) begin
					if (!hv.ok) begin
						len_frz_q <= 1'b1;
					end else begin
						len_q <= {len_q[11:0], hv.val};
					end
				end
				if (fold) begin
					crc_q <= crc_byte(crc_q, tail_q[0]);
				end
				for (int i = 0; i < TAIL_BYTES - 1; i++) begin
					tail_q[i] <= tail_q[i+1];
				end
				tail_q[TAIL_BYTES-1] <= rx_byte;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> sv/ascii_hex_frame_receiver.sv
// ascii hex frame receiver top level: input register, frame logic, result register
// depends on ahfr_pkg and ahfr_frame
//
//  channel  | dir | tdata                                   | tuser | tlast
//  s_*      | in  | [7:0] rx_byte                           | -     | frame_end
//  m_*      | out | payload_byte, status, address,          | kind  | -
//           |     | payload_length, received_crc, pad        |       |
//
// one item per cycle sustained while the result is not stalled; an accepted input is held in the input register,
// then the single-pass frame logic writes its result into the result register
// arst_n clears both valid flags and returns the frame state to its idle values
// a stalled result holds the input register, which stalls s_tready
// items that give no result still pass through the input register

module ascii_hex_frame_receiver
	import ahfr_pkg::*;
#(
	parameter int POSITION_BITS_P = POSITION_BITS
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata, // payload_byte, status, address,
	                                          // payload_length, received_crc, zeros
	output logic        m_tuser    // kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       advance;
	logic       res_valid;
	result_t    res;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	ahfr_frame #(
		.POS_BITS (POSITION_BITS_P)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.frame_end (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {5'd0, res_s2.received_crc, res_s2.payload_length,
		res_s2.address, res_s2.status, res_s2.payload_byte};

endmodule
